[sv/rswa_pkg.sv]
// shared types and constants for the running statistics block
package rswa_pkg;

  localparam int unsigned SampleW = 32;
  localparam int unsigned VarW    = 63;
  localparam int unsigned DevW    = 64;

  // output transaction payload, first field highest
  typedef struct packed {
    logic signed [SampleW-1:0] window_average;
    logic signed [SampleW-1:0] largest;
    logic signed [SampleW-1:0] smallest;
    logic [VarW-1:0]           sample_variance;
    logic signed [SampleW-1:0] running_mean;
    logic [SampleW-1:0]        sample_count;
  } result_t;

  localparam int unsigned ResultW = $bits(result_t);
  localparam int unsigned ResultBytesW = ((ResultW + 7) / 8) * 8;

endpackage

[sv/rswa_div.sv]
// iterative restoring divider, one quotient bit per cycle
module rswa_div
  import rswa_pkg::*;
#(
  parameter int unsigned NumW = 64,
  parameter int unsigned DenW = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quot_q, quot_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DenW:0]   trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[DenW-1:0], quot_q[NumW-1]};
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d  = trial - {1'b0, den_q};
        quot_d = {quot_q[NumW-2:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

[sv/running_stats_with_window_average.sv]
// running statistics (welford) with sliding window average, top level
//
//  channel | dir | fields (lsb first)
//  s_axis  | in  | tdata: sample[31:0]
//  m_axis  | out | tdata: sample_count, running_mean, sample_variance,
//          |     |        smallest, largest, window_average (zero fill to byte)
//
// in steady state each accepted sample takes three passes of the shared
// 64-bit iterative divider (mean step, variance, window average) plus
// control, memory read and update, and no new sample is taken meanwhile
// the first sample after reset skips the mean and variance passes
// the window ring sits in a synchronous memory; read entries are used only once
// the ring is full, so no clearing pass after reset
// a finished result waits in the output register; the next sample is taken
// while it waits, and its own result is held until the register frees
module running_stats_with_window_average
  import rswa_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 128
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [SampleW-1:0]      s_axis_tdata,   // sample
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [ResultBytesW-1:0] m_axis_tdata    // count, mean, variance, min, max, wavg
);

  localparam int unsigned PtrW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned FillW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned TotW  = SampleW + FillW;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_MEAN, S_MEANW, S_D2, S_MUL, S_ACC, S_UPD,
    S_VAR, S_VARW, S_AVG, S_AVGW, S_OUT
  } state_e;

  state_e state_q;

  // running state
  logic [SampleW-1:0]        count_q;
  logic signed [SampleW-1:0] mean_q, low_q, high_q, x_q;
  logic [DevW-1:0]           dev_q;
  logic [PtrW-1:0]           ptr_q;
  logic [FillW-1:0]          fill_q;
  logic signed [TotW-1:0]    total_q;
  logic signed [SampleW:0]   d1_q;
  logic                      d1neg_q;
  logic [SampleW:0]          d2mag_q;
  logic [DevW-1:0]           prod_q;
  logic [VarW-1:0]           var_q;
  logic signed [SampleW-1:0] wavg_q;

  // window memory
  logic signed [SampleW-1:0] win_mem [WINDOW_DEPTH];
  logic signed [SampleW-1:0] win_rd_q;

  // result register
  logic    res_vld_q;
  result_t res_q;

  // shared divider
  logic        div_start;
  logic [63:0] div_num;
  logic [31:0] div_den;
  logic        div_done;
  logic [63:0] div_quot;

  rswa_div #(.NumW(64), .DenW(32)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quot_o(div_quot)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = res_vld_q;
  assign m_axis_tdata  = ResultBytesW'(res_q);

  wire s_fire = s_axis_tvalid && s_axis_tready;
  wire m_fire = m_axis_tvalid && m_axis_tready;

  // result register is loaded from the last state once it is free
  wire res_load = (state_q == S_OUT) && (!res_vld_q || m_fire);

  // combinational helpers
  logic [SampleW-1:0]      cnt_new;
  logic [SampleW:0]        d1_mag;
  logic signed [SampleW:0] step_s, mean_new, d2;
  logic [SampleW:0]        d2_mag;
  logic [2*SampleW+1:0]    prod;
  logic [DevW:0]           dev_sum;
  logic signed [TotW-1:0]  tot_new;
  logic [TotW-1:0]         tot_mag;
  logic signed [SampleW:0] avg_s;

  assign cnt_new  = (count_q == '1) ? count_q : count_q + 1'b1;
  assign d1_mag   = d1_q[SampleW] ? -d1_q : d1_q;
  // mean step magnitude is below 2^31 since the count is at least two
  assign step_s   = d1neg_q ? -$signed({1'b0, div_quot[SampleW-1:0]})
                            : $signed({1'b0, div_quot[SampleW-1:0]});
  assign mean_new = $signed({mean_q[SampleW-1], mean_q}) + step_s;
  // second deviation against the already updated mean
  assign d2       = $signed({x_q[SampleW-1], x_q}) - $signed({mean_q[SampleW-1], mean_q});
  assign d2_mag   = d2[SampleW] ? -d2 : d2;
  // both deviations share a sign, so the product of magnitudes stays below 2^64
  assign prod     = d1_mag * d2mag_q;
  assign dev_sum  = {1'b0, dev_q} + {1'b0, prod_q};
  assign tot_new  = total_q + TotW'(x_q)
                  - ((fill_q == FillW'(WINDOW_DEPTH)) ? TotW'(win_rd_q) : TotW'(0));
  assign tot_mag  = total_q[TotW-1] ? -total_q : total_q;
  assign avg_s    = total_q[TotW-1] ? -$signed({1'b0, div_quot[SampleW-1:0]})
                                    : $signed({1'b0, div_quot[SampleW-1:0]});

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state_q)
      S_MEAN: begin
        div_start = 1'b1;
        div_num   = 64'(d1_mag);
        div_den   = count_q;
      end
      S_VAR: begin
        div_start = (count_q >= 2);
        div_num   = dev_q;
        div_den   = count_q - 1'b1;
      end
      S_AVG: begin
        div_start = 1'b1;
        div_num   = 64'(tot_mag);
        div_den   = 32'(fill_q);
      end
      default: ;
    endcase
  end

  // outgoing entry is read in the same cycle the new sample is written,
  // the read returns the old contents and is held for the total update
  always_ff @(posedge clk_i) begin
    if (state_q == S_RD) begin
      win_mem[ptr_q] <= x_q;
      win_rd_q       <= win_mem[ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      mean_q    <= '0;
      low_q     <= '0;
      high_q    <= '0;
      x_q       <= '0;
      dev_q     <= '0;
      ptr_q     <= '0;
      fill_q    <= '0;
      total_q   <= '0;
      d1_q      <= '0;
      d1neg_q   <= 1'b0;
      d2mag_q   <= '0;
      prod_q    <= '0;
      var_q     <= '0;
      wavg_q    <= '0;
      res_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      if (res_load) res_vld_q <= 1'b1;
      else if (m_fire) res_vld_q <= 1'b0;
      case (state_q)
        S_IDLE: if (s_fire) begin
          x_q     <= s_axis_tdata;
          state_q <= S_RD;
        end
        S_RD: begin
          // memory read of the outgoing entry lands next cycle
          d1_q    <= $signed({x_q[SampleW-1], x_q}) - $signed({mean_q[SampleW-1], mean_q});
          d1neg_q <= ($signed(x_q) < $signed(mean_q));
          if (count_q == '0) begin
            count_q <= SampleW'(1);
            mean_q  <= x_q;
            low_q   <= x_q;
            high_q  <= x_q;
            state_q <= S_UPD;
          end else begin
            count_q <= cnt_new;
            if ($signed(x_q) < low_q)  low_q  <= x_q;
            if ($signed(x_q) > high_q) high_q <= x_q;
            state_q <= S_MEAN;
          end
        end
        S_MEAN:  state_q <= S_MEANW;
        S_MEANW: if (div_done) begin
          mean_q  <= mean_new[SampleW-1:0];
          state_q <= S_D2;
        end
        S_D2: begin
          d2mag_q <= d2_mag;
          state_q <= S_MUL;
        end
        S_MUL: begin
          prod_q  <= prod[DevW-1:0];
          state_q <= S_ACC;
        end
        S_ACC: begin
          // saturating accumulate of the squared deviation
          dev_q   <= dev_sum[DevW] ? '1 : dev_sum[DevW-1:0];
          state_q <= S_UPD;
        end
        S_UPD: begin
          total_q <= tot_new;
          if (fill_q != FillW'(WINDOW_DEPTH)) fill_q <= fill_q + 1'b1;
          ptr_q   <= (ptr_q == PtrW'(WINDOW_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
          state_q <= S_VAR;
        end
        S_VAR: begin
          var_q   <= '0;
          state_q <= (count_q >= 2) ? S_VARW : S_AVG;
        end
        S_VARW: if (div_done) begin
          var_q   <= div_quot[63] ? '1 : div_quot[VarW-1:0];
          state_q <= S_AVG;
        end
        S_AVG:  state_q <= S_AVGW;
        S_AVGW: if (div_done) begin
          wavg_q  <= avg_s[SampleW-1:0];
          state_q <= S_OUT;
        end
        S_OUT: if (res_load) begin
          res_q.sample_count    <= count_q;
          res_q.running_mean    <= mean_q;
          res_q.sample_variance <= var_q;
          res_q.smallest        <= low_q;
          res_q.largest         <= high_q;
          res_q.window_average  <= wavg_q;
          state_q               <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[sv/rswa_checker.sv]
// port-level checks for the running statistics block
module rswa_checker
  import rswa_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    s_axis_tvalid,
  input logic                    s_axis_tready,
  input logic                    m_axis_tvalid,
  input logic                    m_axis_tready,
  input logic [ResultBytesW-1:0] m_axis_tdata
);

  result_t res;
  assign res = result_t'(m_axis_tdata[ResultW-1:0]);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped while stalled");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> res.sample_count != '0)
    else $error("result with zero count");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $signed(res.smallest) <= $signed(res.largest))
    else $error("minimum above maximum");

  a_var: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.sample_count == 1 |-> res.sample_variance == '0)
    else $error("variance nonzero for single sample");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second sample taken while busy");

endmodule

bind running_stats_with_window_average rswa_checker u_rswa_checker (.*);
